// ----- design/rkmc_pkg.sv -----
// Shared types and constants for the rotary knob menu controller.
// No dependencies; every other design file refers to it by scoped names.
package rkmc_pkg;

    // Item kinds carried by the input channel
    typedef enum logic [1:0] {
        KIND_TICK       = 2'd0,
        KIND_VOLUME     = 2'd1,
        KIND_INSTRUMENT = 2'd2,
        KIND_OCTAVE     = 2'd3
    } kind_t;

    // Menu modes
    localparam logic [1:0] MODE_VOLUME     = 2'd0;
    localparam logic [1:0] MODE_INSTRUMENT = 2'd1;
    localparam logic [1:0] MODE_OCTAVE     = 2'd2;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRESS_HOLDOFF  = 2'd0;
    localparam logic [1:0] CFG_ROTATE_HOLDOFF = 2'd1;
    localparam logic [1:0] CFG_VOLUME_STEP    = 2'd2;
    localparam logic [1:0] CFG_MODE_COUNT     = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration reset values
    localparam logic [15:0] PRESS_HOLDOFF_RST  = 16'd200;
    localparam logic [15:0] ROTATE_HOLDOFF_RST = 16'd50;
    localparam logic [6:0]  VOLUME_STEP_RST    = 7'd16;
    localparam logic [2:0]  MODE_COUNT_RST     = 3'd3;

    // State reset values
    localparam logic [1:0] MODE_RST       = MODE_INSTRUMENT;
    localparam logic [7:0] VOLUME_RST     = 8'd63;
    localparam logic [7:0] INSTRUMENT_RST = 8'd0;
    localparam logic [7:0] OCTAVE_RST     = 8'd0;

    // Clamp limits
    localparam logic signed [9:0] LEVEL_MAX  = 10'sd127;
    localparam logic signed [8:0] OCTAVE_MIN = -9'sd3;
    localparam logic signed [8:0] OCTAVE_MAX = 9'sd4;

    typedef struct packed {
        logic [15:0] press_holdoff;
        logic [15:0] rotate_holdoff;
        logic [6:0]  volume_step;
        logic [2:0]  mode_count;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic        clk_pin;
        logic        dt_pin;
        logic        button_pin;
        logic [7:0]  remote_value;
    } item_t;

    typedef struct packed {
        logic [7:0]        volume;
        logic [7:0]        instrument;
        logic signed [7:0] octave;
        logic [1:0]        mode;
    } knob_t;

    // Advance the mode modulo the mode count; zero counts as one, above four as four
    function automatic logic [1:0] mode_wrap(input logic [1:0] mode, input logic [2:0] count);
        logic [2:0] m1;
        logic [1:0] res;
        begin
            m1 = {1'b0, mode} + 3'd1;
            case (count)
                3'd0, 3'd1: res = 2'd0;
                3'd2:       res = {1'b0, m1[0]};
                3'd3:       res = (m1 >= 3'd3) ? 2'(m1 - 3'd3) : m1[1:0];
                default:    res = m1[1:0];
            endcase
            return res;
        end
    endfunction

endpackage

// ----- design/rkmc_cfg.sv -----
// Configuration register file for the rotary knob menu controller.
// Depends on rkmc_pkg for register indexes, reset values and cfg_t.
module rkmc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rkmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rkmc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rkmc_pkg::cfg_t                    cfg
);

    rkmc_pkg::cfg_t cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_holdoff  <= rkmc_pkg::PRESS_HOLDOFF_RST;
            cfg_reg.rotate_holdoff <= rkmc_pkg::ROTATE_HOLDOFF_RST;
            cfg_reg.volume_step    <= rkmc_pkg::VOLUME_STEP_RST;
            cfg_reg.mode_count     <= rkmc_pkg::MODE_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rkmc_pkg::CFG_PRESS_HOLDOFF:  cfg_reg.press_holdoff  <= cfg_data;
                rkmc_pkg::CFG_ROTATE_HOLDOFF: cfg_reg.rotate_holdoff <= cfg_data;
                rkmc_pkg::CFG_VOLUME_STEP:    cfg_reg.volume_step    <= cfg_data[6:0];
                rkmc_pkg::CFG_MODE_COUNT:     cfg_reg.mode_count     <= cfg_data[2:0];
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/rkmc_step.sv -----
// Next-state logic for one item: button, encoder clock edge and remote writes.
// Depends on rkmc_pkg for item_t, knob_t, cfg_t, mode codes and limits.
module rkmc_step #(
    parameter int COUNTER_WIDTH = 16
) (
    input  rkmc_pkg::cfg_t              cfg,
    input  rkmc_pkg::item_t             item,
    input  rkmc_pkg::knob_t             knob,
    input  logic [COUNTER_WIDTH-1:0]    press_elapsed,
    input  logic [COUNTER_WIDTH-1:0]    rotate_elapsed,
    input  logic                        clk_seen,
    input  logic                        clk_accepted,
    output rkmc_pkg::knob_t             knob_next,
    output logic [COUNTER_WIDTH-1:0]    press_elapsed_next,
    output logic [COUNTER_WIDTH-1:0]    rotate_elapsed_next,
    output logic                        clk_seen_next,
    output logic                        clk_accepted_next,
    output logic                        changed
);

    localparam int CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    logic [COUNTER_WIDTH-1:0] press_inc;
    logic [COUNTER_WIDTH-1:0] rotate_inc;
    logic                     press_ok;
    logic                     rotate_ok;
    logic                     knob_step;
    logic                     cw;
    logic [1:0]               mode_tick;
    logic signed [9:0]        vol_sum;
    logic signed [9:0]        inst_sum;
    logic signed [8:0]        oct_sum;
    logic [7:0]               vol_clamped;
    logic [7:0]               inst_clamped;
    logic signed [7:0]        oct_clamped;
    rkmc_pkg::knob_t          knob_tick;

    // Saturating elapsed counters
    assign press_inc  = (press_elapsed == CNT_MAX) ? press_elapsed : press_elapsed + CNT_ONE;
    assign rotate_inc = (rotate_elapsed == CNT_MAX) ? rotate_elapsed : rotate_elapsed + CNT_ONE;

    // Button press and clock change qualification
    assign press_ok  = !item.button_pin &&
                       (CMP_W'(press_inc) > CMP_W'(cfg.press_holdoff));
    assign rotate_ok = (item.clk_pin != clk_seen) &&
                       (CMP_W'(rotate_inc) > CMP_W'(cfg.rotate_holdoff));
    assign knob_step = rotate_ok && (item.clk_pin != clk_accepted);
    assign cw        = item.dt_pin != item.clk_pin;

    assign mode_tick = press_ok ? rkmc_pkg::mode_wrap(knob.mode, cfg.mode_count) : knob.mode;

    // Step and clamp each value
    assign vol_sum  = cw ? $signed({2'b00, knob.volume}) + $signed({3'b000, cfg.volume_step})
                         : $signed({2'b00, knob.volume}) - $signed({3'b000, cfg.volume_step});
    assign inst_sum = cw ? $signed({2'b00, knob.instrument}) + 10'sd1
                         : $signed({2'b00, knob.instrument}) - 10'sd1;
    assign oct_sum  = cw ? $signed({knob.octave[7], knob.octave}) + 9'sd1
                         : $signed({knob.octave[7], knob.octave}) - 9'sd1;

    assign vol_clamped  = (vol_sum < 10'sd0) ? 8'd0 :
                          (vol_sum > rkmc_pkg::LEVEL_MAX) ? 8'(rkmc_pkg::LEVEL_MAX) :
                          vol_sum[7:0];
    assign inst_clamped = (inst_sum < 10'sd0) ? 8'd0 :
                          (inst_sum > rkmc_pkg::LEVEL_MAX) ? 8'(rkmc_pkg::LEVEL_MAX) :
                          inst_sum[7:0];
    assign oct_clamped  = (oct_sum < rkmc_pkg::OCTAVE_MIN) ? 8'(rkmc_pkg::OCTAVE_MIN) :
                          (oct_sum > rkmc_pkg::OCTAVE_MAX) ? 8'(rkmc_pkg::OCTAVE_MAX) :
                          oct_sum[7:0];

    // Apply a tick: mode first, then the knob step in the new mode
    always_comb
    begin
        knob_tick      = knob;
        knob_tick.mode = mode_tick;
        if (knob_step)
        begin
            case (mode_tick)
                rkmc_pkg::MODE_VOLUME:     knob_tick.volume     = vol_clamped;
                rkmc_pkg::MODE_INSTRUMENT: knob_tick.instrument = inst_clamped;
                rkmc_pkg::MODE_OCTAVE:     knob_tick.octave     = oct_clamped;
                default:                   knob_tick = knob_tick;
            endcase
        end
    end

    // Select by item kind; remote writes leave timing state alone
    always_comb
    begin
        knob_next           = knob;
        press_elapsed_next  = press_elapsed;
        rotate_elapsed_next = rotate_elapsed;
        clk_seen_next       = clk_seen;
        clk_accepted_next   = clk_accepted;
        changed             = 1'b0;
        case (item.kind)
            rkmc_pkg::KIND_VOLUME:     knob_next.volume     = item.remote_value;
            rkmc_pkg::KIND_INSTRUMENT: knob_next.instrument = item.remote_value;
            rkmc_pkg::KIND_OCTAVE:     knob_next.octave     = $signed(item.remote_value);
            default:
            begin
                knob_next           = knob_tick;
                press_elapsed_next  = press_ok ? '0 : press_inc;
                rotate_elapsed_next = rotate_ok ? '0 : rotate_inc;
                clk_seen_next       = item.clk_pin;
                clk_accepted_next   = knob_step ? item.clk_pin : clk_accepted;
                changed             = knob_step && (mode_tick != rkmc_pkg::MODE_UNUSED);
            end
        endcase
    end

endmodule

// ----- design/rotary_knob_menu_controller.sv -----
// Rotary knob menu controller: input register, one-pass step logic, result register.
// Path: an accepted item waits in the input register, then loads into the result register.
// Throughput: one item per cycle while out_stall is low; the state registers update in the same cycle as the
// result register, so each item sees the state left by the one before it.
// Reset: rst_n is asynchronous, active low; state and configuration return to defaults.
// Depends on rkmc_pkg, rkmc_cfg and rkmc_step.
module rotary_knob_menu_controller #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rkmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rkmc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic                              clk_pin,
    input  logic                              dt_pin,
    input  logic                              button_pin,
    input  logic [7:0]                        remote_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        volume_out,
    output logic [7:0]                        instrument_out,
    output logic signed [7:0]                 octave_out,
    output logic [1:0]                        mode_out,
    output logic                              changed
);

    rkmc_pkg::cfg_t           cfg;
    rkmc_pkg::item_t          item_reg;
    logic                     item_valid_reg;
    rkmc_pkg::knob_t          knob_reg;
    rkmc_pkg::knob_t          knob_next;
    logic [COUNTER_WIDTH-1:0] press_elapsed_reg;
    logic [COUNTER_WIDTH-1:0] press_elapsed_next;
    logic [COUNTER_WIDTH-1:0] rotate_elapsed_reg;
    logic [COUNTER_WIDTH-1:0] rotate_elapsed_next;
    logic                     clk_seen_reg;
    logic                     clk_seen_next;
    logic                     clk_accepted_reg;
    logic                     clk_accepted_next;
    logic                     changed_next;
    logic                     out_valid_reg;
    rkmc_pkg::knob_t          res_knob_reg;
    logic                     res_changed_reg;
    logic                     out_load;
    logic                     item_move;
    logic                     in_accept;

    rkmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rkmc_step #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_step (
        .cfg                 (cfg),
        .item                (item_reg),
        .knob                (knob_reg),
        .press_elapsed       (press_elapsed_reg),
        .rotate_elapsed      (rotate_elapsed_reg),
        .clk_seen            (clk_seen_reg),
        .clk_accepted        (clk_accepted_reg),
        .knob_next           (knob_next),
        .press_elapsed_next  (press_elapsed_next),
        .rotate_elapsed_next (rotate_elapsed_next),
        .clk_seen_next       (clk_seen_next),
        .clk_accepted_next   (clk_accepted_next),
        .changed             (changed_next)
    );

    // Handshake: the result register loads when empty or being taken
    assign out_load  = !out_valid_reg || !out_stall;
    assign item_move = item_valid_reg && out_load;
    assign in_stall  = item_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.kind         <= rkmc_pkg::kind_t'(kind);
            item_reg.clk_pin      <= clk_pin;
            item_reg.dt_pin       <= dt_pin;
            item_reg.button_pin   <= button_pin;
            item_reg.remote_value <= remote_value;
        end
    end

    // Commit state when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knob_reg.volume     <= rkmc_pkg::VOLUME_RST;
            knob_reg.instrument <= rkmc_pkg::INSTRUMENT_RST;
            knob_reg.octave     <= rkmc_pkg::OCTAVE_RST;
            knob_reg.mode       <= rkmc_pkg::MODE_RST;
            press_elapsed_reg   <= '0;
            rotate_elapsed_reg  <= '0;
            clk_seen_reg        <= 1'b1;
            clk_accepted_reg    <= 1'b1;
        end
        else if (item_move)
        begin
            knob_reg           <= knob_next;
            press_elapsed_reg  <= press_elapsed_next;
            rotate_elapsed_reg <= rotate_elapsed_next;
            clk_seen_reg       <= clk_seen_next;
            clk_accepted_reg   <= clk_accepted_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_move)
        begin
            res_knob_reg    <= knob_next;
            res_changed_reg <= changed_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign volume_out     = res_knob_reg.volume;
    assign instrument_out = res_knob_reg.instrument;
    assign octave_out     = res_knob_reg.octave;
    assign mode_out       = res_knob_reg.mode;
    assign changed        = res_changed_reg;

endmodule

// ----- design/rkmc_checker.sv -----
// Port-level assertions for the rotary knob menu controller, bound to the top level.
// Depends on rkmc_pkg for mode codes.
module rkmc_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [7:0]        volume_out,
    input  logic [7:0]        instrument_out,
    input  logic signed [7:0] octave_out,
    input  logic [1:0]        mode_out,
    input  logic              changed
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(volume_out) &&
        $stable(instrument_out) && $stable(octave_out) && $stable(mode_out) &&
        $stable(changed))
        else $error("stalled result changed");

    // Stall the input only behind a stalled, full result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without back-pressure");

    // A fresh result follows an item that was accepted into the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without an accepted item");

    // A knob step never reports in the unused mode
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && changed |-> mode_out != rkmc_pkg::MODE_UNUSED)
        else $error("knob step reported in unused mode");

    // A knob step in octave mode leaves the octave in its clamp range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && changed && mode_out == rkmc_pkg::MODE_OCTAVE |->
        octave_out >= -8'sd3 && octave_out <= 8'sd4)
        else $error("octave step out of range");

endmodule

bind rotary_knob_menu_controller rkmc_checker u_rkmc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .volume_out     (volume_out),
    .instrument_out (instrument_out),
    .octave_out     (octave_out),
    .mode_out       (mode_out),
    .changed        (changed)
);
